FILE: rtl/ftma_pkg.sv
package ftma_pkg;

	localparam int TIME_W = 31;
	localparam int IN_W = 64;
	localparam int CNT_W = 7;
	localparam int SUM_W = TIME_W + CNT_W;
	localparam int LANES = 3;
	localparam int DIV_STEPS = TIME_W;
	localparam int STEP_W = 5;
	localparam int S_DATA_W = LANES * IN_W;
	localparam int M_DATA_W = 200;
	localparam logic [CNT_W-1:0] WINDOW_RESET = 7'd64;
	localparam logic [TIME_W-1:0] TIME_CAP = 31'h7FFF_FFFF;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_START,
		S_DIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic acc;
		logic div_init;
		logic div_step;
		logic load_out;
	} cmd_t;

	function automatic time_t cap_time(input logic [IN_W-1:0] v);
		return (|v[IN_W-1:TIME_W]) ? TIME_CAP : v[TIME_W-1:0];
	endfunction

endpackage

FILE: rtl/ftma_divider.sv
module ftma_divider (
	input  logic                                           clk,
	input  logic                                           init,
	input  logic                                           step,
	input  ftma_pkg::sum_t  [ftma_pkg::LANES-1:0]          dividend,
	input  ftma_pkg::cnt_t                                 divisor,
	output ftma_pkg::time_t [ftma_pkg::LANES-1:0]          quotient
);

	ftma_pkg::cnt_t  [ftma_pkg::LANES-1:0] rem_q;
	ftma_pkg::time_t [ftma_pkg::LANES-1:0] quo_q;

	// The quotient never exceeds the time cap, so the top dividend bits
	// already form a remainder below the divisor.
	always_ff @(posedge clk) begin
		for (int i = 0; i < ftma_pkg::LANES; i++) begin
			logic [ftma_pkg::CNT_W:0] trial;
			trial = {rem_q[i], quo_q[i][ftma_pkg::TIME_W-1]};
			if (init) begin
				rem_q[i] <= dividend[i][ftma_pkg::SUM_W-1:ftma_pkg::TIME_W];
				quo_q[i] <= dividend[i][ftma_pkg::TIME_W-1:0];
			end else if (step) begin
				if (trial >= {1'b0, divisor}) begin
					rem_q[i] <= ftma_pkg::CNT_W'(trial - {1'b0, divisor});
					quo_q[i] <= {quo_q[i][ftma_pkg::TIME_W-2:0], 1'b1};
				end else begin
					rem_q[i] <= trial[ftma_pkg::CNT_W-1:0];
					quo_q[i] <= {quo_q[i][ftma_pkg::TIME_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quotient = quo_q;

endmodule

FILE: rtl/ftma_ctrl.sv
module ftma_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output ftma_pkg::cmd_t   cmd
);

	ftma_pkg::state_t state_q, state_d;
	ftma_pkg::step_t  step_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ftma_pkg::S_IDLE:  if (s_tvalid) state_d = ftma_pkg::S_ACC;
			ftma_pkg::S_ACC:   state_d = ftma_pkg::S_START;
			ftma_pkg::S_START: state_d = ftma_pkg::S_DIV;
			ftma_pkg::S_DIV: begin
				if (step_q == ftma_pkg::STEP_W'(ftma_pkg::DIV_STEPS - 1))
					state_d = ftma_pkg::S_OUT;
			end
			ftma_pkg::S_OUT:   if (out_free) state_d = ftma_pkg::S_IDLE;
			default:           state_d = ftma_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ftma_pkg::S_IDLE: begin
				s_tready = 1'b1;
				cmd.accept = s_tvalid;
			end
			ftma_pkg::S_ACC:   cmd.acc = 1'b1;
			ftma_pkg::S_START: cmd.div_init = 1'b1;
			ftma_pkg::S_DIV:   cmd.div_step = 1'b1;
			ftma_pkg::S_OUT:   cmd.load_out = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftma_pkg::S_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init)
				step_q <= '0;
			else if (cmd.div_step)
				step_q <= step_q + 1'b1;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

FILE: rtl/ftma_datapath.sv
module ftma_datapath #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ftma_pkg::cmd_t                    cmd,
	input  logic [ftma_pkg::S_DATA_W-1:0]     s_tdata,
	input  logic                              cfg_wr_en,
	input  ftma_pkg::cnt_t                    cfg_wr_data,
	output logic [ftma_pkg::M_DATA_W-1:0]     m_tdata
);

	localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int ROW_W = ftma_pkg::LANES * ftma_pkg::TIME_W;

	ftma_pkg::cnt_t                          window_length_q;
	ftma_pkg::cnt_t                          len;
	ftma_pkg::cnt_t                          count_q;
	logic [PTR_W-1:0]                        ptr_q;
	logic [PTR_W-1:0]                        slot;
	logic [PTR_W-1:0]                        slot_q;
	ftma_pkg::time_t [ftma_pkg::LANES-1:0]   cap_q;
	ftma_pkg::sum_t  [ftma_pkg::LANES-1:0]   sum_q;
	ftma_pkg::time_t [ftma_pkg::LANES-1:0]   quotient;
	logic [ROW_W-1:0]                        ring_mem [WINDOW_DEPTH];
	logic [ROW_W-1:0]                        rd_q;
	logic [ROW_W-1:0]                        wr_row;
	logic                                    full;
	logic                                    wrap;
	logic [ftma_pkg::M_DATA_W-1:0]           out_q;

	always_comb begin
		if (window_length_q == '0)
			len = ftma_pkg::CNT_W'(1);
		else if (32'(window_length_q) > WINDOW_DEPTH)
			len = ftma_pkg::CNT_W'(WINDOW_DEPTH);
		else
			len = window_length_q;
	end

	assign slot = (32'(ptr_q) >= 32'(len)) ? '0 : ptr_q;
	assign full = count_q >= len;
	assign wrap = (32'(slot_q) + 32'd1) >= 32'(len);

	always_comb begin
		for (int i = 0; i < ftma_pkg::LANES; i++)
			wr_row[i*ftma_pkg::TIME_W +: ftma_pkg::TIME_W] = cap_q[i];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			rd_q <= ring_mem[slot];
		if (cmd.acc)
			ring_mem[slot_q] <= wr_row;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			slot_q <= slot;
			for (int i = 0; i < ftma_pkg::LANES; i++)
				cap_q[i] <= ftma_pkg::cap_time(s_tdata[i*ftma_pkg::IN_W +: ftma_pkg::IN_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= ftma_pkg::WINDOW_RESET;
			count_q <= '0;
			ptr_q <= '0;
			sum_q <= '0;
		end else if (cfg_wr_en) begin
			window_length_q <= cfg_wr_data;
			count_q <= '0;
			ptr_q <= '0;
			sum_q <= '0;
		end else if (cmd.acc) begin
			count_q <= full ? len : count_q + 1'b1;
			ptr_q <= wrap ? '0 : PTR_W'(32'(slot_q) + 32'd1);
			for (int i = 0; i < ftma_pkg::LANES; i++) begin
				if (full)
					sum_q[i] <= sum_q[i] + ftma_pkg::SUM_W'(cap_q[i])
						- ftma_pkg::SUM_W'(rd_q[i*ftma_pkg::TIME_W +: ftma_pkg::TIME_W]);
				else
					sum_q[i] <= sum_q[i] + ftma_pkg::SUM_W'(cap_q[i]);
			end
		end
	end

	ftma_divider u_divider (
		.clk      (clk),
		.init     (cmd.div_init),
		.step     (cmd.div_step),
		.dividend (sum_q),
		.divisor  (count_q),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			out_q <= {7'd0, count_q, quotient[2], quotient[1], quotient[0],
				cap_q[2], cap_q[1], cap_q[0]};
	end

	assign m_tdata = out_q;

endmodule

FILE: rtl/frame_time_moving_average_unit.sv
// Moving average of frame times over a sliding window of recent frames.
// Input items arrive on the s_ group: tdata carries the update, draw and
// total times, 64 bits each. Each time is capped to 2147483647 before use.
// Results leave on the m_ group, one result per input item, in order.
// cfg_wr_en writes cfg_wr_data as the window length and clears the window;
// it must only be used while the block is idle.
// After acceptance an item passes through these steps in order: the ring entry
// is read at the accepting edge, then the running sums are updated, the
// divider is loaded, the three-lane restoring divider runs, which retires
// one quotient bit per cycle, and the output register is loaded once free.
// The block accepts one item at a time and is ready again as soon as the
// result is loaded, so it takes no new item until the last one is through.
// The result sits in an output register; a stalled receiver does not stop
// the next item from being accepted, but that item waits for the register
// to free before its result is written.
// After reset the window length is 64 and the window is empty; the ring
// contents are not cleared, since only written entries are ever used.
module frame_time_moving_average_unit #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// update_time, draw_time, total_time
	input  logic [ftma_pkg::S_DATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// last_update, last_draw, last_total, avg_update, avg_draw, avg_total,
	// frames_in_window, zero fill
	output logic [ftma_pkg::M_DATA_W-1:0]     m_tdata,
	input  logic                              cfg_wr_en,
	input  logic [ftma_pkg::CNT_W-1:0]        cfg_wr_data
);

	ftma_pkg::cmd_t cmd;

	ftma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	ftma_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.s_tdata     (s_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.m_tdata     (m_tdata)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again right after an item");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared one cycle after acceptance");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[192:186] != 7'd0)
		else $error("result shows an empty window");

endmodule
